>>> src/hkm_pkg.sv
// ============================================================================
// hkm_pkg
// Shared types, constants and helpers for the k-way merge heap.
// ============================================================================
package hkm_pkg;

    localparam int MAX_RUNS = 16;
    localparam int IDX_W    = $clog2(MAX_RUNS);
    localparam int CNT_W    = IDX_W + 1;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int CFG_W    = 5;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
        logic                    exhausted;
    } t_in_item;

    typedef struct packed {
        logic signed [KEY_W-1:0] out_key;
        logic signed [VAL_W-1:0] out_value;
        logic [IDX_W-1:0]        source_run;
        logic                    all_done;
    } t_out_item;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
        logic [IDX_W-1:0]        run;
        logic                    empty;
    } t_slot;

    typedef struct packed {
        logic accept;
        logic restart;
    } t_hkm_cmd;

    typedef struct packed {
        logic busy;
        logic res_valid;
    } t_hkm_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_GRAB,
        ST_READ,
        ST_CMP,
        ST_ROOT_RD,
        ST_ROOT
    } t_state;

    // empty slots rank above every live key; strict compare keeps ties in place
    function automatic logic ranks_below(input t_slot a, input t_slot b);
        logic r;
        r = !a.empty && (b.empty || (a.key < b.key));
        return r;
    endfunction

endpackage

>>> src/heap_kway_merge.sv
// ============================================================================
// heap_kway_merge
// K-way merge of sorted key/value runs through a binary min-heap in RAM.
//
//  channel | signals                               | beat
//  --------+---------------------------------------+---------------------------
//  in      | i_in_valid  o_in_stall  i_in_data     | run head or next entry
//  out     | o_out_valid i_out_stall o_out_data    | minimum entry or done mark
//  cfg     | i_cfg_valid o_cfg_ready i_cfg_data    | lists_in_use
//
// Head beats during loading, but the last, give no result.
// A merge beat sifts the new entry down from the root, with a read and a
// compare/write-back state for each heap level, then reads out the root.
// The last head runs the build: each parent, last first, is sifted down.
// Reset and a cfg write return to loading; no clearing pass.
// Results sit in an output reg; the engine waits while it is full and stalled.
// ============================================================================
module heap_kway_merge import hkm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic [CFG_W-1:0] r_lists;
    logic             r_out_valid;
    t_out_item        r_out;

    t_hkm_cmd         cmd;
    t_hkm_stat        stat;
    t_out_item        res;
    logic             res_ready;
    logic [CNT_W-1:0] run_count;
    logic             cfg_wr;

    always_comb begin
        if (r_lists == '0) begin
            run_count = CNT_W'(1);
        end else if ({{(32-CFG_W){1'b0}}, r_lists} > MAX_RUNS) begin
            run_count = CNT_W'(MAX_RUNS);
        end else begin
            run_count = CNT_W'(r_lists);
        end
    end

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = stat.busy;
    assign res_ready   = !r_out_valid || !i_out_stall;
    assign cmd.accept  = i_in_valid && !o_in_stall;
    assign cmd.restart = cfg_wr;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    hkm_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_in_data),
        .i_run_count (run_count),
        .i_res_ready (res_ready),
        .o_stat      (stat),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lists     <= CFG_W'(2);
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_lists <= i_cfg_data;
            end
            if (res_ready) begin
                r_out_valid <= stat.res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && stat.res_valid) begin
            r_out <= res;
        end
    end

    // ---- checks ----
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.all_done |->
            (o_out_data.out_key == '0) && (o_out_data.out_value == '0) &&
            (o_out_data.source_run == '0))
        else $error("done beat carries nonzero fields");

    a_res_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.res_valid |-> stat.busy)
        else $error("engine offers a result while idle");

    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> !o_in_stall && !stat.res_valid)
        else $error("engine not back to loading after cfg write");

    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.res_valid && res_ready |=> o_out_valid)
        else $error("result lost on its way to the output register");

endmodule

>>> src/hkm_engine.sv
// ============================================================================
// hkm_engine
// Heap store and sequencer: head loading, bottom-up build, sift-down, root read.
// ============================================================================
module hkm_engine import hkm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_hkm_cmd         i_cmd,
    input  t_in_item         i_item,
    input  logic [CNT_W-1:0] i_run_count,
    input  logic             i_res_ready,
    output t_hkm_stat        o_stat,
    output t_out_item        o_res
);

    t_slot            r_mem [MAX_RUNS];
    t_slot            r_rd_a;
    t_slot            r_rd_b;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_heads;
    logic             r_merging;
    logic [IDX_W-1:0] r_j;
    logic [IDX_W-1:0] r_node;
    logic [IDX_W-1:0] r_last_run;
    t_slot            r_cur;

    logic [CNT_W-1:0] load_pos;
    logic [CNT_W-1:0] n_heads;
    logic [CNT_W-1:0] last_parent;
    logic             load_done;
    logic [CNT_W:0]   left_pos;
    logic [CNT_W:0]   right_pos;
    logic             left_ok;
    logic             right_ok;
    logic             take_left;
    logic             take_right;
    logic             move;
    logic [IDX_W-1:0] child_idx;
    t_slot            child_slot;
    logic             sift_end;

    logic [IDX_W-1:0] rd_addr_a;
    logic [IDX_W-1:0] rd_addr_b;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_slot            wr_data;

    // ---- datapath decode ----
    always_comb begin
        load_pos    = (r_heads >= i_run_count) ? i_run_count - CNT_W'(1) : r_heads;
        n_heads     = load_pos + CNT_W'(1);
        load_done   = n_heads >= i_run_count;
        last_parent = (i_run_count - CNT_W'(1)) >> 1;
        left_pos    = {1'b0, r_node, 1'b1};
        right_pos   = {1'b0, r_node, 1'b0} + (CNT_W+1)'(2);
        left_ok     = left_pos  < {1'b0, i_run_count};
        right_ok    = right_pos < {1'b0, i_run_count};
        take_left   = left_ok && ranks_below(r_rd_a, r_cur);
        take_right  = right_ok && (take_left ? ranks_below(r_rd_b, r_rd_a)
                                             : ranks_below(r_rd_b, r_cur));
        move        = take_left || take_right;
        child_idx   = take_right ? right_pos[IDX_W-1:0] : left_pos[IDX_W-1:0];
        child_slot  = take_right ? r_rd_b : r_rd_a;
        sift_end    = (r_state == ST_CMP) && !move;
    end

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd.accept) begin
                    if (r_merging) begin
                        n_state = ST_READ;
                    end else if (load_done) begin
                        n_state = ST_FETCH;
                    end
                end
            end
            ST_FETCH:   n_state = ST_GRAB;
            ST_GRAB:    n_state = ST_READ;
            ST_READ:    n_state = ST_CMP;
            ST_CMP: begin
                if (move) begin
                    n_state = ST_READ;
                end else if (!r_merging && (r_j != '0)) begin
                    n_state = ST_FETCH;
                end else begin
                    n_state = ST_ROOT_RD;
                end
            end
            ST_ROOT_RD: n_state = ST_ROOT;
            ST_ROOT: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // ---- memory port control and outputs ----
    always_comb begin
        rd_addr_a = '0;
        rd_addr_b = '0;
        wr_en     = 1'b0;
        wr_addr   = r_node;
        wr_data   = r_cur;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd.accept && !r_merging) begin
                    wr_en   = 1'b1;
                    wr_addr = load_pos[IDX_W-1:0];
                    wr_data = '{key: i_item.key, value: i_item.value,
                                run: load_pos[IDX_W-1:0], empty: i_item.exhausted};
                end
            end
            ST_FETCH: rd_addr_a = r_j;
            ST_READ: begin
                rd_addr_a = left_pos[IDX_W-1:0];
                rd_addr_b = right_pos[IDX_W-1:0];
            end
            ST_CMP: begin
                wr_en   = 1'b1;
                wr_data = move ? child_slot : r_cur;
            end
            default: ;
        endcase

        o_stat.busy      = r_state != ST_IDLE;
        o_stat.res_valid = r_state == ST_ROOT;
        if (r_rd_a.empty) begin
            o_res = '{out_key: '0, out_value: '0, source_run: '0, all_done: 1'b1};
        end else begin
            o_res = '{out_key: r_rd_a.key, out_value: r_rd_a.value,
                      source_run: r_rd_a.run, all_done: 1'b0};
        end
    end

    // ---- heap store ----
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_a <= r_mem[rd_addr_a];
        r_rd_b <= r_mem[rd_addr_b];
    end

    // ---- control state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_state   <= ST_IDLE;
            r_heads   <= '0;
            r_merging <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_IDLE) && i_cmd.accept && !r_merging) begin
                r_heads <= n_heads;
            end
            if ((r_state == ST_ROOT) && i_res_ready) begin
                r_merging <= !r_rd_a.empty;
                if (r_rd_a.empty) begin
                    r_heads <= '0;
                end
            end
        end
    end

    // ---- sift payload ----
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_cmd.accept) begin
                    r_j    <= last_parent[IDX_W-1:0];
                    r_node <= '0;
                    r_cur  <= '{key: i_item.key, value: i_item.value,
                               run: r_last_run, empty: i_item.exhausted};
                end
            end
            ST_GRAB: begin
                r_cur  <= r_rd_a;
                r_node <= r_j;
            end
            ST_CMP: begin
                if (move) begin
                    r_node <= child_idx;
                end else if (sift_end && !r_merging && (r_j != '0)) begin
                    r_j <= r_j - IDX_W'(1);
                end
            end
            ST_ROOT: begin
                if (i_res_ready) begin
                    r_last_run <= r_rd_a.run;
                end
            end
            default: ;
        endcase
    end

endmodule
